// File: design/assert_macros.svh
// Concurrent check helpers; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define DOPL_CHECK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When trig holds, prop must hold in the following cycle.
`define DOPL_CHECK_NEXT(name, clk, rst_n, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`else

`define DOPL_CHECK(name, clk, rst_n, prop, msg)
`define DOPL_CHECK_NEXT(name, clk, rst_n, trig, prop, msg)

`endif

`endif

// File: design/dopl_pkg.sv
package dopl_pkg;

    localparam int POOL_SLOTS_DEF   = 2048;
    localparam int VERTEX_SLOTS_DEF = 4096;

    localparam int MODE_W    = 3;
    localparam int DEPTH_W   = 16;
    localparam int VCOUNT_W  = 8;
    localparam int TAG_W     = 16;

    localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BACK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SORTED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_LINK,
        ST_RD_DATA,
        ST_LINK_RD,
        ST_LINK_CHK,
        ST_DEPTH_CHK,
        ST_FIN_NEW,
        ST_FIN_PREV,
        ST_RESP
    } t_state;

endpackage

// File: design/dopl_mem.sv
module dopl_mem
    import dopl_pkg::*;
#(
    parameter int WIDTH  = 12,
    parameter int DEPTH  = POOL_SLOTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/depth_ordered_polygon_list.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// input    | i_in_valid / o_in_stall | i_mode i_depth_key i_vertex_count i_poly_tag
// output   | o_out_valid/ i_out_stall| o_node_slot o_vertex_start o_tag_out
//          |                         | o_list_done o_pool_full
//
// A sorted insert takes longer for each node it passes; the walk is bound by the
// single read port of the link memory: nodes are visited one at a time, with one
// compare unit shared by all steps.
// Reset (synchronous, active low) clears the sequencer, list pointers and the two
// sentinel links; node memories are not cleared and need no clearing pass.
// A finished result waits in the output register while the next transaction is
// accepted; a held o_out_valid blocks only the final result load.
module depth_ordered_polygon_list
    import dopl_pkg::*;
#(
    parameter int POOL_SLOTS   = POOL_SLOTS_DEF,
    parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [MODE_W-1:0]               i_mode,
    input  logic signed [DEPTH_W-1:0]       i_depth_key,
    input  logic [VCOUNT_W-1:0]             i_vertex_count,
    input  logic [TAG_W-1:0]                i_poly_tag,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [$clog2(POOL_SLOTS)-1:0]   o_node_slot,
    output logic [$clog2(VERTEX_SLOTS)-1:0] o_vertex_start,
    output logic [TAG_W-1:0]                o_tag_out,
    output logic                            o_list_done,
    output logic                            o_pool_full
);

`include "assert_macros.svh"

    localparam int SLOT_W    = $clog2(POOL_SLOTS);
    localparam int LINK_W    = SLOT_W + 1;
    localparam int HALF_POOL = POOL_SLOTS / 2;
    localparam int VERT_W    = $clog2(VERTEX_SLOTS);
    localparam int TOT_W     = VERT_W + 1;
    localparam int HALF_VERT = VERTEX_SLOTS / 2;
    localparam int SUM_W     = ((TOT_W > VCOUNT_W) ? TOT_W : VCOUNT_W) + 1;
    localparam int DATA_W    = DEPTH_W + TAG_W + VERT_W;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SLOTS);

    t_state r_state, n_state;

    // list state
    logic                    r_half, n_half;
    logic [SLOT_W-1:0]       r_tail, n_tail;
    logic [SLOT_W-1:0]       r_sort_begin, n_sort_begin;
    logic [LINK_W-1:0]       r_sort_limit, n_sort_limit;
    logic [LINK_W-1:0]       r_next_free, n_next_free;
    logic [TOT_W-1:0]        r_vertex_total, n_vertex_total;
    logic [SLOT_W-1:0]       r_read_cursor, n_read_cursor;
    logic [LINK_W-1:0]       r_sent_lo, n_sent_lo;
    logic [LINK_W-1:0]       r_sent_hi, n_sent_hi;
    logic                    r_out_valid, n_out_valid;

    // transaction and walk registers
    logic [MODE_W-1:0]       r_mode, n_mode;
    logic signed [DEPTH_W-1:0] r_key, n_key;
    logic [VCOUNT_W-1:0]     r_vcnt, n_vcnt;
    logic [TAG_W-1:0]        r_tag, n_tag;
    logic [SLOT_W-1:0]       r_cur, n_cur;
    logic [SLOT_W-1:0]       r_cand, n_cand;
    logic [LINK_W-1:0]       r_lnk, n_lnk;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [SLOT_W-1:0]       r_res_slot, n_res_slot;
    logic [VERT_W-1:0]       r_res_vstart, n_res_vstart;
    logic [TAG_W-1:0]        r_res_tag, n_res_tag;
    logic                    r_res_done, n_res_done;
    logic                    r_res_full, n_res_full;
    logic [SLOT_W-1:0]       r_out_slot, n_out_slot;
    logic [VERT_W-1:0]       r_out_vstart, n_out_vstart;
    logic [TAG_W-1:0]        r_out_tag, n_out_tag;
    logic                    r_out_done, n_out_done;
    logic                    r_out_full, n_out_full;

    // memory ports
    logic                    w_link_we;
    logic [SLOT_W-1:0]       w_link_waddr;
    logic [LINK_W-1:0]       w_link_wdata;
    logic [SLOT_W-1:0]       w_link_raddr;
    logic [LINK_W-1:0]       w_link_rdata;
    logic                    w_data_we;
    logic [SLOT_W-1:0]       w_data_waddr;
    logic [DATA_W-1:0]       w_data_wdata;
    logic [SLOT_W-1:0]       w_data_raddr;
    logic [DATA_W-1:0]       w_data_rdata;

    // derived values
    logic [LINK_W-1:0]       w_base, w_base_end, w_new_base;
    logic [TOT_W-1:0]        w_vbase, w_vend;
    logic [SUM_W-1:0]        w_vsum;
    logic                    w_insert, w_full;
    logic [LINK_W-1:0]       w_half_sent;
    logic                    w_cur_is_sent, w_cursor_is_sent;
    logic [LINK_W-1:0]       w_cur_link, w_cursor_link;
    logic                    w_walk_stop;
    logic signed [DEPTH_W-1:0] w_node_depth;
    logic [TAG_W-1:0]        w_node_tag;
    logic [VERT_W-1:0]       w_node_start;
    logic                    w_key_ge;
    logic                    w_out_free;

    dopl_mem #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_SLOTS)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_link_raddr),
        .o_rdata (w_link_rdata)
    );

    dopl_mem #(
        .WIDTH (DATA_W),
        .DEPTH (POOL_SLOTS)
    ) u_data_mem (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (w_data_waddr),
        .i_wdata (w_data_wdata),
        .i_raddr (w_data_raddr),
        .o_rdata (w_data_rdata)
    );

    always_comb begin
        w_base     = r_half ? LINK_W'(HALF_POOL)  : '0;
        w_base_end = r_half ? LINK_W'(POOL_SLOTS) : LINK_W'(HALF_POOL);
        w_new_base = r_half ? '0 : LINK_W'(HALF_POOL);
        w_vbase    = r_half ? TOT_W'(HALF_VERT)    : '0;
        w_vend     = r_half ? TOT_W'(VERTEX_SLOTS) : TOT_W'(HALF_VERT);
        w_vsum     = SUM_W'(r_vertex_total) + SUM_W'(r_vcnt);
        w_insert   = (r_mode == MODE_FRONT) || (r_mode == MODE_BACK) ||
                     (r_mode == MODE_SORTED);
        w_full     = (r_next_free >= w_base_end) || r_next_free[SLOT_W] ||
                     (w_vsum > SUM_W'(w_vend));
        w_half_sent = r_half ? r_sent_hi : r_sent_lo;

        // sentinel links live in registers, node links in memory
        w_cur_is_sent    = (r_cur[SLOT_W-2:0] == '0);
        w_cursor_is_sent = (r_read_cursor[SLOT_W-2:0] == '0);
        if (w_cur_is_sent) begin
            w_cur_link = r_cur[SLOT_W-1] ? r_sent_hi : r_sent_lo;
        end else begin
            w_cur_link = w_link_rdata;
        end
        if (w_cursor_is_sent) begin
            w_cursor_link = r_read_cursor[SLOT_W-1] ? r_sent_hi : r_sent_lo;
        end else begin
            w_cursor_link = w_link_rdata;
        end

        w_walk_stop  = (w_cur_link == r_sort_limit) || w_cur_link[SLOT_W];
        w_node_depth = w_data_rdata[DATA_W-1 -: DEPTH_W];
        w_node_tag   = w_data_rdata[VERT_W +: TAG_W];
        w_node_start = w_data_rdata[VERT_W-1:0];
        w_key_ge     = (r_key >= w_node_depth);
        w_out_free   = !r_out_valid || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_insert) begin
                    if (w_full || (r_mode == MODE_FRONT)) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_LINK_RD;
                    end
                end else if (r_mode == MODE_READ) begin
                    n_state = ST_RD_LINK;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_RD_LINK: begin
                n_state = w_cursor_link[SLOT_W] ? ST_RESP : ST_RD_DATA;
            end
            ST_RD_DATA:   n_state = ST_RESP;
            ST_LINK_RD:   n_state = ST_LINK_CHK;
            ST_LINK_CHK: begin
                if ((r_mode == MODE_BACK) || w_walk_stop) begin
                    n_state = ST_FIN_NEW;
                end else begin
                    n_state = ST_DEPTH_CHK;
                end
            end
            ST_DEPTH_CHK: begin
                n_state = w_key_ge ? ST_FIN_NEW : ST_LINK_CHK;
            end
            ST_FIN_NEW:   n_state = ST_FIN_PREV;
            ST_FIN_PREV:  n_state = ST_RESP;
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // memory ports and stall
    always_comb begin
        o_in_stall   = (r_state != ST_IDLE);
        w_link_we    = 1'b0;
        w_link_waddr = r_slot;
        w_link_wdata = r_lnk;
        w_link_raddr = r_cur;
        w_data_we    = 1'b0;
        w_data_waddr = r_next_free[SLOT_W-1:0];
        w_data_wdata = {r_key, r_tag, r_vertex_total[VERT_W-1:0]};
        w_data_raddr = r_cand;
        unique case (r_state)
            ST_EXEC: begin
                w_link_raddr = r_read_cursor;
                if (w_insert && !w_full) begin
                    w_data_we = 1'b1;
                    if (r_mode == MODE_FRONT) begin
                        w_link_we    = 1'b1;
                        w_link_waddr = r_next_free[SLOT_W-1:0];
                        w_link_wdata = w_half_sent;
                    end
                end
            end
            ST_RD_LINK: begin
                w_data_raddr = w_cursor_link[SLOT_W-1:0];
            end
            ST_LINK_CHK: begin
                // fetch link and depth of the candidate together
                w_link_raddr = w_cur_link[SLOT_W-1:0];
                w_data_raddr = w_cur_link[SLOT_W-1:0];
            end
            ST_DEPTH_CHK: begin
                w_link_raddr = r_cand;
            end
            ST_FIN_NEW: begin
                w_link_we = 1'b1;
            end
            ST_FIN_PREV: begin
                w_link_we    = !w_cur_is_sent;
                w_link_waddr = r_cur;
                w_link_wdata = {1'b0, r_slot};
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_half         = r_half;
        n_tail         = r_tail;
        n_sort_begin   = r_sort_begin;
        n_sort_limit   = r_sort_limit;
        n_next_free    = r_next_free;
        n_vertex_total = r_vertex_total;
        n_read_cursor  = r_read_cursor;
        n_sent_lo      = r_sent_lo;
        n_sent_hi      = r_sent_hi;
        n_mode         = r_mode;
        n_key          = r_key;
        n_vcnt         = r_vcnt;
        n_tag          = r_tag;
        n_cur          = r_cur;
        n_cand         = r_cand;
        n_lnk          = r_lnk;
        n_slot         = r_slot;
        n_res_slot     = r_res_slot;
        n_res_vstart   = r_res_vstart;
        n_res_tag      = r_res_tag;
        n_res_done     = r_res_done;
        n_res_full     = r_res_full;
        n_out_slot     = r_out_slot;
        n_out_vstart   = r_out_vstart;
        n_out_tag      = r_out_tag;
        n_out_done     = r_out_done;
        n_out_full     = r_out_full;
        n_out_valid    = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_mode;
                    n_key  = i_depth_key;
                    n_vcnt = i_vertex_count;
                    n_tag  = i_poly_tag;
                end
            end
            ST_EXEC: begin
                n_res_slot   = '0;
                n_res_vstart = '0;
                n_res_tag    = '0;
                n_res_done   = 1'b0;
                n_res_full   = 1'b0;
                if (w_insert) begin
                    if (w_full) begin
                        n_res_full = 1'b1;
                    end else begin
                        n_slot         = r_next_free[SLOT_W-1:0];
                        n_res_slot     = r_next_free[SLOT_W-1:0];
                        n_res_vstart   = r_vertex_total[VERT_W-1:0];
                        n_next_free    = r_next_free + LINK_W'(1);
                        n_vertex_total = w_vsum[TOT_W-1:0];
                        priority case (r_mode)
                            MODE_FRONT: begin
                                if (r_half) begin
                                    n_sent_hi = {1'b0, r_next_free[SLOT_W-1:0]};
                                end else begin
                                    n_sent_lo = {1'b0, r_next_free[SLOT_W-1:0]};
                                end
                                if ({1'b0, r_sort_begin} == w_base) begin
                                    n_sort_begin = r_next_free[SLOT_W-1:0];
                                end
                                if (w_half_sent[SLOT_W]) begin
                                    n_tail = r_next_free[SLOT_W-1:0];
                                end
                            end
                            MODE_BACK:   n_cur = r_tail;
                            default:     n_cur = r_sort_begin;
                        endcase
                    end
                end else if (r_mode == MODE_SWAP) begin
                    n_read_cursor = w_base[SLOT_W-1:0];
                    n_half        = !r_half;
                    if (r_half) begin
                        n_sent_lo = LINK_NULL;
                    end else begin
                        n_sent_hi = LINK_NULL;
                    end
                    n_tail         = w_new_base[SLOT_W-1:0];
                    n_sort_begin   = w_new_base[SLOT_W-1:0];
                    n_sort_limit   = LINK_NULL;
                    n_next_free    = w_new_base + LINK_W'(1);
                    n_vertex_total = r_half ? '0 : TOT_W'(HALF_VERT);
                end
            end
            ST_RD_LINK: begin
                if (w_cursor_link[SLOT_W]) begin
                    n_res_done = 1'b1;
                end else begin
                    n_read_cursor = w_cursor_link[SLOT_W-1:0];
                    n_cand        = w_cursor_link[SLOT_W-1:0];
                end
            end
            ST_RD_DATA: begin
                n_res_slot   = r_cand;
                n_res_vstart = w_node_start;
                n_res_tag    = w_node_tag;
            end
            ST_LINK_CHK: begin
                if ((r_mode == MODE_BACK) || w_walk_stop) begin
                    n_lnk = w_cur_link;
                end else begin
                    n_cand = w_cur_link[SLOT_W-1:0];
                end
            end
            ST_DEPTH_CHK: begin
                if (w_key_ge) begin
                    n_lnk = {1'b0, r_cand};
                end else begin
                    n_cur = r_cand;
                end
            end
            ST_FIN_NEW: begin
                if (r_lnk[SLOT_W]) begin
                    n_tail = r_slot;
                end
            end
            ST_FIN_PREV: begin
                if (w_cur_is_sent) begin
                    if (r_cur[SLOT_W-1]) begin
                        n_sent_hi = {1'b0, r_slot};
                    end else begin
                        n_sent_lo = {1'b0, r_slot};
                    end
                end
                // first back insert closes the sorted region
                if ((r_mode == MODE_BACK) && (r_sort_limit == LINK_NULL)) begin
                    n_sort_limit = {1'b0, r_slot};
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_vstart = r_res_vstart;
                    n_out_tag    = r_res_tag;
                    n_out_done   = r_res_done;
                    n_out_full   = r_res_full;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_half         <= 1'b1;
            r_tail         <= SLOT_W'(HALF_POOL);
            r_sort_begin   <= SLOT_W'(HALF_POOL);
            r_sort_limit   <= LINK_NULL;
            r_next_free    <= LINK_W'(HALF_POOL + 1);
            r_vertex_total <= TOT_W'(HALF_VERT);
            r_read_cursor  <= '0;
            r_sent_lo      <= LINK_NULL;
            r_sent_hi      <= LINK_NULL;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_half         <= n_half;
            r_tail         <= n_tail;
            r_sort_begin   <= n_sort_begin;
            r_sort_limit   <= n_sort_limit;
            r_next_free    <= n_next_free;
            r_vertex_total <= n_vertex_total;
            r_read_cursor  <= n_read_cursor;
            r_sent_lo      <= n_sent_lo;
            r_sent_hi      <= n_sent_hi;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_vcnt       <= n_vcnt;
        r_tag        <= n_tag;
        r_cur        <= n_cur;
        r_cand       <= n_cand;
        r_lnk        <= n_lnk;
        r_slot       <= n_slot;
        r_res_slot   <= n_res_slot;
        r_res_vstart <= n_res_vstart;
        r_res_tag    <= n_res_tag;
        r_res_done   <= n_res_done;
        r_res_full   <= n_res_full;
        r_out_slot   <= n_out_slot;
        r_out_vstart <= n_out_vstart;
        r_out_tag    <= n_out_tag;
        r_out_done   <= n_out_done;
        r_out_full   <= n_out_full;
    end

    assign o_out_valid    = r_out_valid;
    assign o_node_slot    = r_out_slot;
    assign o_vertex_start = r_out_vstart;
    assign o_tag_out      = r_out_tag;
    assign o_list_done    = r_out_done;
    assign o_pool_full    = r_out_full;

    `DOPL_CHECK(a_free_in_half, i_clk, i_rst_n, (r_next_free > w_base) && (r_next_free <= w_base_end), "free pointer left the building half")
    `DOPL_CHECK(a_vertex_in_half, i_clk, i_rst_n, (r_vertex_total >= w_vbase) && (r_vertex_total <= w_vend), "vertex total left the half range")
    `DOPL_CHECK(a_done_xor_full, i_clk, i_rst_n, !(o_out_valid && o_list_done && o_pool_full), "result flags both done and full")
    `DOPL_CHECK_NEXT(a_depth_after_link, i_clk, i_rst_n, r_state != ST_LINK_CHK, r_state != ST_DEPTH_CHK, "depth check without link check")

endmodule

// File: dv/depth_ordered_polygon_list_tb.sv
`timescale 1ns / 1ps

module depth_ordered_polygon_list_tb;
    import dopl_pkg::*;

    localparam int SLOTS        = POOL_SLOTS_DEF;
    localparam int VERTS        = VERTEX_SLOTS_DEF;
    localparam int HALF_SLOTS   = SLOTS / 2;
    localparam int HALF_VERTS   = VERTS / 2;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int VSTART_W     = $clog2(VERTS);
    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [SLOT_W:0] NO_NODE = SLOTS;

    // modes the block ignores
    localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_C = 3'd7;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [VSTART_W-1:0] vstart;
        logic [TAG_W-1:0]    tag;
        logic                done;
        logic                full;
    } poly_result_t;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_stall;
    logic [MODE_W-1:0]          i_mode         = '0;
    logic signed [DEPTH_W-1:0]  i_depth_key    = '0;
    logic [VCOUNT_W-1:0]        i_vertex_count = '0;
    logic [TAG_W-1:0]           i_poly_tag     = '0;
    logic                       o_out_valid;
    logic                       i_out_stall    = 1'b0;
    logic [SLOT_W-1:0]          o_node_slot;
    logic [VSTART_W-1:0]        o_vertex_start;
    logic [TAG_W-1:0]           o_tag_out;
    logic                       o_list_done;
    logic                       o_pool_full;

    depth_ordered_polygon_list uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_depth_key    (i_depth_key),
        .i_vertex_count (i_vertex_count),
        .i_poly_tag     (i_poly_tag),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_node_slot    (o_node_slot),
        .o_vertex_start (o_vertex_start),
        .o_tag_out      (o_tag_out),
        .o_list_done    (o_list_done),
        .o_pool_full    (o_pool_full)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", awaited_list_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // Display list predictor
    // ---------------------------------------------------------------
    logic [SLOT_W:0]    ml_link  [SLOTS];
    logic [DEPTH_W-1:0] ml_depth [SLOTS];
    logic [TAG_W-1:0]   ml_tag   [SLOTS];
    logic [VSTART_W-1:0] ml_start [SLOTS];
    logic [SLOT_W-1:0]  ml_tail;
    logic [SLOT_W-1:0]  ml_sort_head;
    logic [SLOT_W:0]    ml_sort_end;
    logic [SLOT_W:0]    ml_next_free;
    logic [SLOT_W:0]    ml_cursor;
    logic [VSTART_W:0]  ml_vtotal;
    logic               ml_half;

    poly_result_t awaited_list_results[$];

    int  items_sent;
    int  results_seen;
    int  failures;
    int  inserts_placed;
    int  inserts_dropped;
    int  swaps_done;
    int  nodes_read;
    int  reads_at_end;
    bit  steady_flow;
    int  out_hold_left;

    function automatic int link_at(input int s);
        return (s < SLOTS) ? int'(ml_link[s]) : SLOTS;
    endfunction

    function automatic void open_half();
        int base;
        base = ml_half ? HALF_SLOTS : 0;
        ml_link[base] = NO_NODE;
        ml_tail       = SLOT_W'(base);
        ml_sort_head  = SLOT_W'(base);
        ml_sort_end   = NO_NODE;
        ml_next_free  = (SLOT_W+1)'(base + 1);
        ml_vtotal     = ml_half ? (VSTART_W+1)'(HALF_VERTS) : '0;
    endfunction

    function automatic void reset_list_model();
        for (int s = 0; s < SLOTS; s++) begin
            ml_link[s]  = '0;
            ml_depth[s] = '0;
            ml_tag[s]   = '0;
            ml_start[s] = '0;
        end
        ml_link[0]          = NO_NODE;
        ml_link[HALF_SLOTS] = NO_NODE;
        ml_half             = 1'b1;
        open_half();
        ml_cursor           = '0;
    endfunction

    function automatic poly_result_t predict_list_op(
        input logic [MODE_W-1:0]         mode,
        input logic signed [DEPTH_W-1:0] depth,
        input logic [VCOUNT_W-1:0]       vcount,
        input logic [TAG_W-1:0]          tag
    );
        poly_result_t r;
        int base;
        int vbase;
        int slot;
        int cur;
        int nxt;
        r     = '0;
        base  = ml_half ? HALF_SLOTS : 0;
        vbase = ml_half ? HALF_VERTS : 0;
        case (mode)
            MODE_FRONT, MODE_BACK, MODE_SORTED: begin
                if (int'(ml_next_free) >= base + HALF_SLOTS || int'(ml_next_free) >= SLOTS ||
                    int'(ml_vtotal) + int'(vcount) > vbase + HALF_VERTS) begin
                    r.full = 1'b1;
                    inserts_dropped++;
                end else begin
                    slot = int'(ml_next_free);
                    ml_depth[slot] = depth;
                    ml_tag[slot]   = tag;
                    ml_start[slot] = ml_vtotal[VSTART_W-1:0];
                    if (mode == MODE_FRONT) begin
                        ml_link[slot] = ml_link[base];
                        ml_link[base] = (SLOT_W+1)'(slot);
                        if (int'(ml_sort_head) == base)
                            ml_sort_head = SLOT_W'(slot);
                    end else if (mode == MODE_BACK) begin
                        ml_link[slot]    = ml_link[ml_tail];
                        ml_link[ml_tail] = (SLOT_W+1)'(slot);
                        if (ml_sort_end == NO_NODE)
                            ml_sort_end = (SLOT_W+1)'(slot);
                    end else begin
                        // walk the sorted region; stop before the first node not deeper
                        cur = int'(ml_sort_head);
                        for (int steps = 0; steps < SLOTS; steps++) begin
                            nxt = link_at(cur);
                            if (nxt == int'(ml_sort_end) || nxt >= SLOTS)
                                break;
                            if (depth >= $signed(ml_depth[nxt]))
                                break;
                            cur = nxt;
                        end
                        ml_link[slot] = (SLOT_W+1)'(link_at(cur));
                        ml_link[cur]  = (SLOT_W+1)'(slot);
                    end
                    if (ml_link[slot] >= NO_NODE)
                        ml_tail = SLOT_W'(slot);
                    ml_next_free = ml_next_free + 1'b1;
                    r.slot       = SLOT_W'(slot);
                    r.vstart     = ml_vtotal[VSTART_W-1:0];
                    ml_vtotal    = ml_vtotal + vcount;
                    inserts_placed++;
                end
            end
            MODE_SWAP: begin
                ml_cursor = (SLOT_W+1)'(base);
                ml_half   = ~ml_half;
                open_half();
                swaps_done++;
            end
            MODE_READ: begin
                nxt = link_at(int'(ml_cursor));
                if (nxt >= SLOTS) begin
                    r.done = 1'b1;
                    reads_at_end++;
                end else begin
                    ml_cursor = (SLOT_W+1)'(nxt);
                    r.slot    = SLOT_W'(nxt);
                    r.vstart  = ml_start[nxt];
                    r.tag     = ml_tag[nxt];
                    nodes_read++;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void log_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s", what);
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stall per transaction, compare in order
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        poly_result_t got;
        poly_result_t want;
        int           hold;
        if (!i_rst_n) begin
            out_hold_left = 0;
        end else if (o_out_valid && !i_out_stall) begin
            got.slot   = o_node_slot;
            got.vstart = o_vertex_start;
            got.tag    = o_tag_out;
            got.done   = o_list_done;
            got.full   = o_pool_full;
            results_seen++;
            if (awaited_list_results.size() == 0) begin
                log_failure($sformatf("result %0d arrived with nothing outstanding", results_seen));
            end else begin
                want = awaited_list_results.pop_front();
                if (got.slot !== want.slot || got.vstart !== want.vstart ||
                    got.tag !== want.tag || got.done !== want.done || got.full !== want.full)
                    log_failure($sformatf({"result %0d mismatch (expected/actual): slot %0d/%0d ",
                        "vstart %0d/%0d tag %h/%h done %b/%b full %b/%b"}, results_seen,
                        want.slot, got.slot, want.vstart, got.vstart, want.tag, got.tag,
                        want.done, got.done, want.full, got.full));
            end
            hold = steady_flow ? 0 : $urandom_range(0, 3);
            out_hold_left = hold;
            i_out_stall <= (hold != 0);
        end else if (out_hold_left > 0) begin
            out_hold_left--;
            if (out_hold_left == 0)
                i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------
    task automatic send_op(
        input  logic [MODE_W-1:0]         mode,
        input  logic signed [DEPTH_W-1:0] depth,
        input  logic [VCOUNT_W-1:0]       vcount,
        input  logic [TAG_W-1:0]          tag,
        output poly_result_t              res
    );
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode         <= mode;
        i_depth_key    <= depth;
        i_vertex_count <= vcount;
        i_poly_tag     <= tag;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = predict_list_op(mode, depth, vcount, tag);
        awaited_list_results.push_back(res);
        items_sent++;
    endtask

    // hold the sender until every outstanding transaction has returned
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_list_results.size() != 0);
    endtask

    task automatic read_out_list(input int extra);
        poly_result_t res;
        do send_op(MODE_READ, $urandom, $urandom, $urandom, res); while (!res.done);
        for (int k = 0; k < extra; k++)
            send_op(MODE_READ, $urandom, $urandom, $urandom, res);
    endtask

    task automatic test_empty_lists();
        poly_result_t res;
        send_op(MODE_READ, DEPTH_MAX, 8'hFF, 16'hFFFF, res);
        send_op(MODE_READ, DEPTH_MIN, 8'h00, 16'h0000, res);
        send_op(MODE_RSVD_A, DEPTH_MAX, 8'hFF, 16'hFFFF, res);
        send_op(MODE_RSVD_B, DEPTH_MIN, 8'h80, 16'h8000, res);
        send_op(MODE_RSVD_C, 16'sh5A5A, 8'h7F, 16'h7FFF, res);
        send_op(MODE_SWAP, $urandom, $urandom, $urandom, res);
        send_op(MODE_READ, $urandom, $urandom, $urandom, res);
        send_op(MODE_READ, $urandom, $urandom, $urandom, res);
    endtask

    task automatic test_directed_frame();
        poly_result_t res;
        send_op(MODE_FRONT,  DEPTH_MIN, 8'hFF, 16'hFFFF, res);
        send_op(MODE_SORTED, DEPTH_MAX, 8'h00, 16'h0001, res);
        send_op(MODE_SORTED, 16'sd0,    8'h01, 16'h0002, res);
        // equal depth lands ahead of the earlier node
        send_op(MODE_SORTED, 16'sd0,    8'h02, 16'h0003, res);
        send_op(MODE_SORTED, DEPTH_MIN, 8'h03, 16'h0004, res);
        send_op(MODE_BACK,   DEPTH_MAX, 8'hFF, 16'h0000, res);
        send_op(MODE_SORTED, -16'sd1,   8'h10, 16'h0005, res);
        send_op(MODE_FRONT,  16'sd0,    8'h00, 16'h5555, res);
        send_op(MODE_BACK,   16'sd0,    8'h80, 16'hAAAA, res);
        send_op(MODE_SORTED, DEPTH_MAX, 8'h01, 16'h0006, res);
        send_op(MODE_SWAP, $urandom, $urandom, $urandom, res);
        read_out_list(1);
    endtask

    // run the vertex index exactly to the end of the half, once per half
    task automatic test_vertex_limit();
        poly_result_t     res;
        logic [MODE_W-1:0] mode;
        for (int pass = 0; pass < 2; pass++) begin
            send_op(MODE_SWAP, $urandom, $urandom, $urandom, res);
            read_out_list(0);
            for (int k = 0; k < 8; k++) begin
                mode = (k % 3 == 0) ? MODE_FRONT : (k % 3 == 1) ? MODE_BACK : MODE_SORTED;
                send_op(mode, $urandom, 8'hFF, $urandom, res);
            end
            send_op(MODE_SORTED, $urandom, 8'h08, $urandom, res);
            send_op(MODE_FRONT,  $urandom, 8'h01, $urandom, res);
            send_op(MODE_BACK,   $urandom, 8'h00, $urandom, res);
            send_op(MODE_SORTED, $urandom, 8'h00, $urandom, res);
            send_op(MODE_SORTED, $urandom, 8'hFF, $urandom, res);
        end
        send_op(MODE_SWAP, $urandom, $urandom, $urandom, res);
        read_out_list(1);
    endtask

    task automatic test_pool_exhaustion();
        poly_result_t     res;
        logic [MODE_W-1:0] mode;
        int               limit;
        int               roll;
        for (int pass = 0; pass < 2; pass++) begin
            steady_flow = (pass == 1);
            send_op(MODE_SWAP, $urandom, $urandom, $urandom, res);
            limit = (ml_half ? HALF_SLOTS : 0) + HALF_SLOTS;
            // mostly front/back so the sorted walk stays short
            while (int'(ml_next_free) < limit) begin
                roll = $urandom_range(0, 31);
                mode = (roll == 0) ? MODE_SORTED : roll[0] ? MODE_FRONT : MODE_BACK;
                send_op(mode, $urandom, $urandom_range(0, 2), $urandom, res);
            end
            send_op(MODE_FRONT,  $urandom, 8'h00, $urandom, res);
            send_op(MODE_BACK,   $urandom, 8'h00, $urandom, res);
            send_op(MODE_SORTED, $urandom, 8'h00, $urandom, res);
            wait_all_results();
            send_op(MODE_SWAP, $urandom, $urandom, $urandom, res);
            read_out_list(2);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random_frames();
        poly_result_t               res;
        logic [MODE_W-1:0]          mode;
        logic signed [DEPTH_W-1:0]  depth;
        logic [VCOUNT_W-1:0]        vcount;
        int                         first;
        int                         count;
        int                         roll;
        bit                         narrow;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            steady_flow = ($urandom_range(0, 5) == 0);
            narrow      = $urandom_range(0, 1);
            count       = $urandom_range(0, 40);
            for (int k = 0; k < count; k++) begin
                roll   = $urandom_range(0, 19);
                depth  = narrow ? $urandom_range(0, 4) - 2 : $urandom;
                vcount = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 15);
                if (roll == 0)
                    mode = $urandom_range(0, 7);
                else if (roll == 1)
                    mode = MODE_READ;
                else if (roll < 8)
                    mode = MODE_FRONT;
                else if (roll < 12)
                    mode = MODE_BACK;
                else
                    mode = MODE_SORTED;
                send_op(mode, depth, vcount, $urandom, res);
            end
            if ($urandom_range(0, 7) == 0)
                wait_all_results();
            send_op(MODE_SWAP, $urandom, $urandom, $urandom, res);
            if ($urandom_range(0, 5) == 0) begin
                // stop partway through the finished list
                count = $urandom_range(0, 3);
                for (int k = 0; k < count; k++)
                    send_op(MODE_READ, $urandom, $urandom, $urandom, res);
            end else begin
                read_out_list($urandom_range(0, 2));
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        reset_list_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_lists();
        test_directed_frame();
        test_vertex_limit();
        test_pool_exhaustion();
        test_random_frames();
        wait_all_results();
        repeat (40) @(posedge i_clk);
        $display("%0d transactions: %0d polygons placed, %0d inserts dropped, %0d swaps",
                 items_sent, inserts_placed, inserts_dropped, swaps_done);
        $display("%0d nodes read back, %0d reads past the list end, %0d failures",
                 nodes_read, reads_at_end, failures);
        if (failures == 0 && awaited_list_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
